@@ design/keyword_intent_classifier_macros.svh @@
// Assertion helpers shared by the classifier modules.
`ifndef KEYWORD_INTENT_CLASSIFIER_MACROS_SVH
`define KEYWORD_INTENT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KIC_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KIC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/kic_pkg.sv @@
package kic_pkg;

    localparam int BYTE_W    = 8;
    localparam int WIN_DEPTH = 7;
    localparam int WIN_W     = BYTE_W * (WIN_DEPTH + 1);
    localparam int NUM_KW    = 9;

    typedef enum logic [3:0] {
        CLS_EDIT     = 4'd0,
        CLS_CREATE   = 4'd1,
        CLS_DELETE   = 4'd2,
        CLS_BUILD    = 4'd3,
        CLS_TERMINAL = 4'd4,
        CLS_SEARCH   = 4'd5,
        CLS_REFACTOR = 4'd6,
        CLS_DEBUG    = 4'd7,
        CLS_AGENT    = 4'd8,
        CLS_CHAT     = 4'd9
    } intent_class_t;

    typedef logic [NUM_KW-1:0] kw_vec_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [BYTE_W-1:0] folded;
    } kic_stage_t;

    // Newest byte sits in the low byte of the window.
    localparam logic [WIN_W-1:0] KW_TEXT [NUM_KW] = '{
        64'h0000_0000_6564_6974,  // edit
        64'h0000_6372_6561_7465,  // create
        64'h0000_6465_6c65_7465,  // delete
        64'h0000_0062_7569_6c64,  // build
        64'h7465_726d_696e_616c,  // terminal
        64'h0000_7365_6172_6368,  // search
        64'h7265_6661_6374_6f72,  // refactor
        64'h0000_0064_6562_7567,  // debug
        64'h0000_0061_6765_6e74   // agent
    };

    localparam logic [WIN_W-1:0] KW_MASK [NUM_KW] = '{
        64'h0000_0000_ffff_ffff,
        64'h0000_ffff_ffff_ffff,
        64'h0000_ffff_ffff_ffff,
        64'h0000_00ff_ffff_ffff,
        64'hffff_ffff_ffff_ffff,
        64'h0000_ffff_ffff_ffff,
        64'hffff_ffff_ffff_ffff,
        64'h0000_00ff_ffff_ffff,
        64'h0000_00ff_ffff_ffff
    };

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b inside {[8'h41:8'h5a]})
        begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

@@ design/kic_if.sv @@
interface kic_byte_if
    import kic_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_prompt;

    modport source (output valid, output text_byte, output end_of_prompt, input ready);
    modport sink   (input valid, input text_byte, input end_of_prompt, output ready);
endinterface

interface kic_class_if;
    logic       valid;
    logic       ready;
    logic [3:0] intent_class;

    modport source (output valid, output intent_class, input ready);
    modport sink   (input valid, input intent_class, output ready);
endinterface

@@ design/kic_in_stage.sv @@
module kic_in_stage
    import kic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kic_byte_if.sink   prompt_in,
    input  logic       advance,
    output kic_stage_t stage
);

    logic              valid_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] folded_reg;
    logic              take;

    assign prompt_in.ready = !valid_reg || advance;
    assign take            = prompt_in.valid && prompt_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg   <= prompt_in.end_of_prompt;
            folded_reg <= fold_byte(prompt_in.text_byte);
        end
    end

    assign stage = '{valid: valid_reg, last: last_reg, folded: folded_reg};

endmodule

@@ design/kic_matcher.sv @@
`include "keyword_intent_classifier_macros.svh"

module kic_matcher
    import kic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  kic_stage_t stage,
    input  logic       advance,
    output kw_vec_t    seen_now
);

    logic [WIN_W-BYTE_W-1:0] window_reg;
    logic [WIN_W-1:0]        full_win;
    kw_vec_t                 seen_reg;
    kw_vec_t                 hits;

    assign full_win = {window_reg, stage.folded};

    always_comb
    begin
        for (int k = 0; k < NUM_KW; k++)
        begin
            hits[k] = ((full_win ^ KW_TEXT[k]) & KW_MASK[k]) == '0;
        end
    end

    assign seen_now = seen_reg | hits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
        end
        else if (advance)
        begin
            if (stage.last)
            begin
                window_reg <= '0;
                seen_reg   <= '0;
            end
            else
            begin
                window_reg <= full_win[WIN_W-BYTE_W-1:0];
                seen_reg   <= seen_now;
            end
        end
    end

    `KIC_ASSERT_NEXT(a_clear_after_last, advance && stage.last,
                     seen_reg == '0 && window_reg == '0, "state not cleared after last byte")

endmodule

@@ design/keyword_intent_classifier.sv @@
// A last byte's class is registered as that byte leaves the input register.
// Throughput: one byte per cycle; a waiting result stalls only a next last byte.
// Input register, then nine parallel window compares and a priority pick into
// the result register.
// Reset (rst_n, async, active low) clears the window, keyword flags and valids.
`include "keyword_intent_classifier_macros.svh"

module keyword_intent_classifier
    import kic_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    kic_byte_if.sink     prompt_in,
    kic_class_if.source  class_out
);

    kic_stage_t    stage;
    kw_vec_t       seen_now;
    logic          advance;
    intent_class_t pick;
    logic          out_valid_reg;
    intent_class_t out_class_reg;

    assign advance = stage.valid && (!stage.last || !out_valid_reg || class_out.ready);

    kic_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .prompt_in (prompt_in),
        .advance   (advance),
        .stage     (stage)
    );

    kic_matcher u_matcher (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .advance  (advance),
        .seen_now (seen_now)
    );

    always_comb
    begin
        pick = CLS_CHAT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (seen_now[k])
            begin
                pick = intent_class_t'(4'(k));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && stage.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (class_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage.last)
        begin
            out_class_reg <= pick;
        end
    end

    assign class_out.valid        = out_valid_reg;
    assign class_out.intent_class = out_class_reg;

    `KIC_ASSERT_NOW(a_class_range, class_out.valid,
                    class_out.intent_class <= CLS_CHAT, "class out of range")
    `KIC_ASSERT_NEXT(a_last_gives_result, advance && stage.last,
                     class_out.valid, "last byte produced no result")
    `KIC_ASSERT_NEXT(a_stalled_last_held, stage.valid && stage.last && !advance,
                     stage.valid && stage.last, "pending last byte dropped")

endmodule

@@ verif/keyword_intent_classifier_test.sv @@
`timescale 1ns / 1ps

module keyword_intent_classifier_test
    import kic_pkg::*;
();

    class intent_scoreboard;
        logic [BYTE_W-1:0] recent [WIN_DEPTH];
        kw_vec_t           seen;
        intent_class_t     expected_classes [$];
        int                errors;

        function new();
            errors = 0;
            clear_prompt();
        endfunction

        function void clear_prompt();
            foreach (recent[i])
            begin
                recent[i] = '0;
            end
            seen = '0;
        endfunction

        static function string keyword_text(int k);
            case (intent_class_t'(k))
                CLS_EDIT:     return "edit";
                CLS_CREATE:   return "create";
                CLS_DELETE:   return "delete";
                CLS_BUILD:    return "build";
                CLS_TERMINAL: return "terminal";
                CLS_SEARCH:   return "search";
                CLS_REFACTOR: return "refactor";
                CLS_DEBUG:    return "debug";
                CLS_AGENT:    return "agent";
                default:      return "";
            endcase
        endfunction

        function int pending();
            return expected_classes.size();
        endfunction

        function void note_request(logic [BYTE_W-1:0] raw, logic last);
            logic [BYTE_W-1:0] win [WIN_DEPTH+1];
            logic [BYTE_W-1:0] cur;
            string             kw;
            int                base;
            bit                hit;
            intent_class_t     cls;
            cur = (raw >= 8'h41 && raw <= 8'h5a) ? raw + 8'd32 : raw;
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win[i] = recent[i];
            end
            win[WIN_DEPTH] = cur;
            for (int k = 0; k < NUM_KW; k++)
            begin
                kw   = keyword_text(k);
                base = WIN_DEPTH + 1 - kw.len();
                hit  = 1'b1;
                for (int i = 0; i < kw.len(); i++)
                begin
                    if (win[base+i] != kw[i])
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    seen[k] = 1'b1;
                end
            end
            for (int i = 0; i < WIN_DEPTH - 1; i++)
            begin
                recent[i] = recent[i+1];
            end
            recent[WIN_DEPTH-1] = cur;
            if (last)
            begin
                cls = CLS_CHAT;
                for (int k = NUM_KW - 1; k >= 0; k--)
                begin
                    if (seen[k])
                    begin
                        cls = intent_class_t'(k);
                    end
                end
                expected_classes.insert(expected_classes.size(), cls);
                clear_prompt();
            end
        endfunction

        function void check_class(logic [3:0] actual);
            intent_class_t exp_cls;
            if (expected_classes.size() == 0)
            begin
                $display("%0t: unexpected intent_class %0d, nothing expected", $time, actual);
                errors++;
                return;
            end
            exp_cls = expected_classes.pop_front();
            if (actual !== exp_cls)
            begin
                $display("%0t: intent_class expected %0d (%s) got %0d",
                         $time, exp_cls, exp_cls.name(), actual);
                errors++;
            end
        endfunction
    endclass

    localparam int TARGET_BYTES = 1050;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   sent_bytes;

    intent_scoreboard sb;

    kic_byte_if  prompt_if();
    kic_class_if class_if();

    keyword_intent_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .prompt_in (prompt_if),
        .class_out (class_if)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("keyword_intent_classifier_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && class_if.valid && class_if.ready)
        begin
            sb.check_class(class_if.intent_class);
        end
    end

    // result side back-pressure
    initial
    begin
        int gap;
        bit burst;
        class_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        burst = 1'b0;
        forever
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst = ~burst;
            end
            gap = burst ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                class_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            class_if.ready <= 1'b1;
            @(posedge clk);
            while (!class_if.valid)
            begin
                @(posedge clk);
            end
        end
    end

    task automatic send_prompt(logic [BYTE_W-1:0] bytes [$], bit burst);
        int gap;
        for (int i = 0; i < bytes.size(); i++)
        begin
            gap = burst ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                prompt_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            prompt_if.valid         <= 1'b1;
            prompt_if.text_byte     <= bytes[i];
            prompt_if.end_of_prompt <= (i == bytes.size() - 1);
            @(posedge clk);
            while (!prompt_if.ready)
            begin
                @(posedge clk);
            end
            sb.note_request(bytes[i], i == bytes.size() - 1);
            sent_bytes++;
        end
    endtask

    task automatic send_text(string s);
        logic [BYTE_W-1:0] bytes [$];
        for (int i = 0; i < s.len(); i++)
        begin
            bytes.insert(bytes.size(), s[i]);
        end
        send_prompt(bytes, 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [BYTE_W-1:0] random_case(logic [BYTE_W-1:0] ch);
        if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(0, 1))
        begin
            return ch - 8'd32;
        end
        return ch;
    endfunction

    task automatic build_prompt(ref logic [BYTE_W-1:0] bytes [$]);
        string kw;
        int    mode;
        int    segs;
        int    cut;
        bytes.delete();
        mode = $urandom_range(0, 9);
        if (mode >= 8)
        begin
            // raw noise, full byte range
            repeat ($urandom_range(1, 12))
            begin
                bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end
            return;
        end
        segs = $urandom_range(1, 3);
        repeat (segs)
        begin
            kw = sb.keyword_text(int'($urandom_range(0, NUM_KW - 1)));
            case ($urandom_range(0, 5))
                0, 1, 2:
                begin
                    if (mode >= 6)
                    begin
                        // damaged keyword: one byte replaced
                        cut = $urandom_range(0, kw.len() - 1);
                        for (int i = 0; i < kw.len(); i++)
                        begin
                            bytes.insert(bytes.size(),
                                         i == cut ? 8'($urandom_range(0, 255))
                                                  : random_case(kw[i]));
                        end
                    end
                    else
                    begin
                        for (int i = 0; i < kw.len(); i++)
                        begin
                            bytes.insert(bytes.size(), random_case(kw[i]));
                        end
                    end
                end
                3:
                begin
                    cut = $urandom_range(1, kw.len() - 1);
                    for (int i = 0; i < cut; i++)
                    begin
                        bytes.insert(bytes.size(), random_case(kw[i]));
                    end
                end
                4:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        bytes.insert(bytes.size(),
                                     random_case(8'($urandom_range(8'h61, 8'h7a))));
                    end
                end
                default:
                begin
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 127)));
                end
            endcase
        end
    endtask

    initial
    begin
        logic [BYTE_W-1:0] bytes [$];
        sb          = new();
        cycle_count = 0;
        sent_bytes  = 0;
        rst_n                   <= 1'b0;
        prompt_if.valid         <= 1'b0;
        prompt_if.text_byte     <= '0;
        prompt_if.end_of_prompt <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keyword ending on the last byte, mixed case
        send_text("eDiT");
        // keyword split across two prompts must not match
        send_text("ed");
        send_text("it");
        // two keywords, lower class wins
        send_text("agentDEBUG");
        // single zero byte and single all-ones byte
        bytes = '{8'h00};
        send_prompt(bytes, 1'b1);
        bytes = '{8'hff};
        send_prompt(bytes, 1'b0);
        // high byte is not folded
        bytes = '{8'he5, 8'h64, 8'h69, 8'h74};
        send_prompt(bytes, 1'b0);

        while (sent_bytes < TARGET_BYTES)
        begin
            build_prompt(bytes);
            send_prompt(bytes, $urandom_range(0, 3) == 0);
        end
        prompt_if.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("keyword_intent_classifier_test: PASS");
        end
        else
        begin
            $display("keyword_intent_classifier_test: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/kic_pkg.sv
design/kic_if.sv
design/kic_in_stage.sv
design/kic_matcher.sv
design/keyword_intent_classifier.sv
verif/keyword_intent_classifier_test.sv
